### sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, also checked during reset.
`define ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/csp_pkg.sv
package csp_pkg;

  localparam int COORD_W   = 32;
  localparam int REG_W     = 31;
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 32;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS,
    REG_HALF_HEIGHT,
    REG_EPS
  } cfg_reg_t;

  // Data that rides along the square-root chain.
  typedef struct packed {
    logic [61:0]        num_x;
    logic [61:0]        num_z;
    logic               neg_x;
    logic               neg_z;
    logic               zero_xz;
    logic [COORD_W-1:0] py;
  } sq_side_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [32:0] rem;
    logic [31:0] root;
    sq_side_t    side;
  } sq_stage_t;

  typedef struct packed {
    logic               neg_x;
    logic               neg_z;
    logic               zero_xz;
    logic [COORD_W-1:0] py;
  } div_side_t;

  typedef struct packed {
    logic [32:0] rem_x;
    logic [32:0] rem_z;
    logic [31:0] low_x;
    logic [31:0] low_z;
    logic [31:0] q_x;
    logic [31:0] q_z;
    logic [32:0] d;
    div_side_t   side;
  } div_stage_t;

endpackage

### sv/cylinder_support_point_unit.sv
// The pipeline holds 69 register stages (3 front stages, 32 square-root cells,
// 1 setup stage, 32 divider cells, output register).
// Throughput: one item per cycle; the chain stalls only while its last cell and the
// output register are both full and out_tready is low.
// Reset (rst_n low, synchronous): all valid bits clear, radius and
// half_height return to 1.0, eps to one LSB.
module cylinder_support_point_unit
  import csp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [127:0]         in_tdata,   // dir_x, dir_y, dir_z, crust, 1 bit pad
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [95:0]          out_tdata,  // point_x, point_y, point_z
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  logic [REG_W-1:0] radius_r, half_height_r, eps_r;
  logic adv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= REG_W'(65536);
      half_height_r <= REG_W'(65536);
      eps_r         <= REG_W'(1);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_RADIUS:      radius_r      <= cfg_data;
        REG_HALF_HEIGHT: half_height_r <= cfg_data;
        REG_EPS:         eps_r         <= cfg_data;
        default: ;
      endcase
    end
  end
  assign cfg_ready = 1'b1;

  // Stage A: capture the input transfer.
  logic a_valid_r;
  logic signed [COORD_W-1:0] a_x_r, a_y_r, a_z_r;
  logic [REG_W-1:0] a_crust_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_x_r     <= in_tdata[31:0];
      a_y_r     <= in_tdata[63:32];
      a_z_r     <= in_tdata[95:64];
      a_crust_r <= in_tdata[126:96];
    end
  end

  // Stage B: magnitudes and products.
  logic [31:0] ax, ay, az;
  logic signed [31:0] r_s, h_s;
  logic [30:0] r_mag;
  logic [63:0] sq_x_nxt, sq_y_nxt, sq_z_nxt, num_x_nxt, num_z_nxt;
  logic [61:0] e2_nxt;
  logic [31:0] py_pre_nxt;

  always_comb begin
    ax    = a_x_r[31] ? 32'(-a_x_r) : 32'(a_x_r);
    ay    = a_y_r[31] ? 32'(-a_y_r) : 32'(a_y_r);
    az    = a_z_r[31] ? 32'(-a_z_r) : 32'(a_z_r);
    r_s   = $signed({1'b0, radius_r}) - $signed({1'b0, a_crust_r});
    h_s   = $signed({1'b0, half_height_r}) - $signed({1'b0, a_crust_r});
    r_mag = r_s[31] ? 31'(-r_s) : r_s[30:0];
    sq_x_nxt  = 64'(ax) * 64'(ax);
    sq_y_nxt  = 64'(ay) * 64'(ay);
    sq_z_nxt  = 64'(az) * 64'(az);
    num_x_nxt = 64'(ax) * 64'(r_mag);
    num_z_nxt = 64'(az) * 64'(r_mag);
    e2_nxt    = 62'(eps_r) * 62'(eps_r);
    if (ay < {1'b0, eps_r}) begin
      py_pre_nxt = '0;
    end else begin
      py_pre_nxt = a_y_r[31] ? 32'(-h_s) : 32'(h_s);
    end
  end

  logic b_valid_r;
  logic [62:0] b_sq_x_r, b_sq_y_r, b_sq_z_r;
  logic [61:0] b_num_x_r, b_num_z_r, b_e2_r;
  logic b_neg_x_r, b_neg_z_r;
  logic [31:0] b_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_sq_x_r  <= sq_x_nxt[62:0];
      b_sq_y_r  <= sq_y_nxt[62:0];
      b_sq_z_r  <= sq_z_nxt[62:0];
      b_num_x_r <= num_x_nxt[61:0];
      b_num_z_r <= num_z_nxt[61:0];
      b_e2_r    <= e2_nxt;
      b_neg_x_r <= a_x_r[31] ^ r_s[31];
      b_neg_z_r <= a_z_r[31] ^ r_s[31];
      b_py_r    <= py_pre_nxt;
    end
  end

  // Stage C: length tests, seed the square-root chain.
  logic [63:0] s2, s3;
  logic short_dir, axial_dir;
  sq_stage_t c_nxt;

  always_comb begin
    s2 = {1'b0, b_sq_x_r} + {1'b0, b_sq_z_r};
    s3 = s2 + {1'b0, b_sq_y_r};
    short_dir = s3 <= {2'b00, b_e2_r};
    axial_dir = s2 <= {2'b00, b_e2_r};
    c_nxt.rad          = s2;
    c_nxt.rem          = '0;
    c_nxt.root         = '0;
    c_nxt.side.num_x   = b_num_x_r;
    c_nxt.side.num_z   = b_num_z_r;
    c_nxt.side.neg_x   = b_neg_x_r;
    c_nxt.side.neg_z   = b_neg_z_r;
    c_nxt.side.zero_xz = short_dir | axial_dir;
    c_nxt.side.py      = short_dir ? '0 : b_py_r;
  end

  logic      sq_v [SQ_STEPS+1];
  sq_stage_t sq_s [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v[0] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_s[0] <= c_nxt;
    end
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    csp_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (sq_v[i]),
      .in_stage  (sq_s[i]),
      .out_valid (sq_v[i+1]),
      .out_stage (sq_s[i+1])
    );
  end

  // Stage D: rounded division setup, N = 2*num + s, D = 2*s.
  sq_stage_t  sq_tail;
  div_stage_t d_nxt;
  logic [63:0] n_x, n_z;

  always_comb begin
    sq_tail = sq_s[SQ_STEPS];
    n_x = {1'b0, sq_tail.side.num_x, 1'b0} + {32'd0, sq_tail.root};
    n_z = {1'b0, sq_tail.side.num_z, 1'b0} + {32'd0, sq_tail.root};
    d_nxt.rem_x = {1'b0, n_x[63:32]};
    d_nxt.rem_z = {1'b0, n_z[63:32]};
    d_nxt.low_x = n_x[31:0];
    d_nxt.low_z = n_z[31:0];
    d_nxt.q_x   = '0;
    d_nxt.q_z   = '0;
    d_nxt.d     = {sq_tail.root, 1'b0};
    d_nxt.side.neg_x   = sq_tail.side.neg_x;
    d_nxt.side.neg_z   = sq_tail.side.neg_z;
    d_nxt.side.zero_xz = sq_tail.side.zero_xz;
    d_nxt.side.py      = sq_tail.side.py;
  end

  logic       dv_v [DIV_STEPS+1];
  div_stage_t dv_s [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sq_v[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_s[0] <= d_nxt;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    csp_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (dv_v[i]),
      .in_stage  (dv_s[i]),
      .out_valid (dv_v[i+1]),
      .out_stage (dv_s[i+1])
    );
  end

  // Output register; the chain moves whenever its last cell can drain.
  div_stage_t dv_tail;
  logic tail_valid;
  logic out_valid_r, out_valid_nxt;
  logic [95:0] out_data_r, out_data_nxt;

  assign dv_tail    = dv_s[DIV_STEPS];
  assign tail_valid = dv_v[DIV_STEPS];
  assign adv        = !tail_valid || !out_valid_r || out_tready;
  assign in_tready  = adv;

  always_comb begin
    out_data_nxt[63:32] = dv_tail.side.py;
    if (dv_tail.side.zero_xz) begin
      out_data_nxt[31:0]  = '0;
      out_data_nxt[95:64] = '0;
    end else begin
      out_data_nxt[31:0]  = dv_tail.side.neg_x ? 32'(-dv_tail.q_x) : dv_tail.q_x;
      out_data_nxt[95:64] = dv_tail.side.neg_z ? 32'(-dv_tail.q_z) : dv_tail.q_z;
    end
    if (adv && tail_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### sv/csp_sqrt_cell.sv
module csp_sqrt_cell
  import csp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  sq_stage_t in_stage,
  output logic      out_valid,
  output sq_stage_t out_stage
);

  logic      valid_r;
  sq_stage_t stage_r;
  sq_stage_t stage_nxt;
  logic [34:0] trial;
  logic [34:0] sub;
  logic [34:0] diff;
  logic        ge;

  // One root bit per cell: bring down the next two radicand bits.
  always_comb begin
    trial = {in_stage.rem, in_stage.rad[63:62]};
    sub   = {1'b0, in_stage.root, 2'b01};
    diff  = trial - sub;
    ge    = trial >= sub;
    stage_nxt      = in_stage;
    stage_nxt.rad  = {in_stage.rad[61:0], 2'b00};
    stage_nxt.rem  = ge ? diff[32:0] : trial[32:0];
    stage_nxt.root = {in_stage.root[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;

endmodule

### sv/csp_div_cell.sv
module csp_div_cell
  import csp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  div_stage_t in_stage,
  output logic       out_valid,
  output div_stage_t out_stage
);

  logic       valid_r;
  div_stage_t stage_r;
  div_stage_t stage_nxt;
  logic [33:0] trial_x;
  logic [33:0] trial_z;
  logic [33:0] diff_x;
  logic [33:0] diff_z;
  logic        ge_x;
  logic        ge_z;

  // One quotient bit per lane and cell, restoring form.
  always_comb begin
    trial_x = {in_stage.rem_x, in_stage.low_x[31]};
    trial_z = {in_stage.rem_z, in_stage.low_z[31]};
    diff_x  = trial_x - {1'b0, in_stage.d};
    diff_z  = trial_z - {1'b0, in_stage.d};
    ge_x    = trial_x >= {1'b0, in_stage.d};
    ge_z    = trial_z >= {1'b0, in_stage.d};
    stage_nxt       = in_stage;
    stage_nxt.rem_x = ge_x ? diff_x[32:0] : trial_x[32:0];
    stage_nxt.rem_z = ge_z ? diff_z[32:0] : trial_z[32:0];
    stage_nxt.low_x = {in_stage.low_x[30:0], 1'b0};
    stage_nxt.low_z = {in_stage.low_z[30:0], 1'b0};
    stage_nxt.q_x   = {in_stage.q_x[30:0], ge_x};
    stage_nxt.q_z   = {in_stage.q_z[30:0], ge_z};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;

endmodule

### sv/csp_checker.sv
`include "assert_macros.svh"

module csp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic        cfg_ready
);

  logic out_stall;
  assign out_stall = out_tvalid && !out_tready;

  // An empty output register never blocks the input side.
  `ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready)
  // Configuration writes are always taken.
  `ASSERT_IMPL(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)
  // Nothing comes out right after reset.
  `ASSERT_NEXT(a_reset_clears, clk, !rst_n, !out_tvalid)
  // A stalled result holds.
  `ASSERT_NEXT(a_out_hold, clk, rst_n && out_stall,
               out_tvalid && $stable(out_tdata))

endmodule

bind cylinder_support_point_unit csp_checker u_csp_checker (.*);

### test/cylinder_support_point_unit_test.sv
module cylinder_support_point_unit_test;
  import csp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [127:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [95:0] out_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  int idle_cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  cylinder_support_point_unit dut (.*);

  class support_scoreboard;
    logic [30:0] radius_q, half_height_q, eps_q;
    point_t expected_points[$];
    int errors;

    function new();
      radius_q = 31'd65536;
      half_height_q = 31'd65536;
      eps_q = 31'd1;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [30:0] val);
      case (idx)
        REG_RADIUS: radius_q = val;
        REG_HALF_HEIGHT: half_height_q = val;
        REG_EPS: eps_q = val;
        default: ;
      endcase
    endfunction

    // round(c * r / s), ties away from zero
    function logic [31:0] scale_wall(logic signed [63:0] c, logic signed [63:0] r,
                                     logic [63:0] s);
      logic [63:0] mc, mr, num, q;
      mc = c < 0 ? -c : c;
      mr = r < 0 ? -r : r;
      num = mc * mr;
      q = (2 * num + s) / (2 * s);
      return ((c < 0) != (r < 0)) ? -q[31:0] : q[31:0];
    endfunction

    function void note_direction(logic [127:0] d);
      logic signed [63:0] vx, vy, vz, r, h;
      logic [63:0] ax, ay, az, s2, s3, e2, s, rem, t;
      point_t p;
      vx = 64'($signed(d[31:0]));
      vy = 64'($signed(d[63:32]));
      vz = 64'($signed(d[95:64]));
      r = $signed({33'd0, radius_q}) - $signed({33'd0, d[126:96]});
      h = $signed({33'd0, half_height_q}) - $signed({33'd0, d[126:96]});
      ax = vx < 0 ? -vx : vx;
      ay = vy < 0 ? -vy : vy;
      az = vz < 0 ? -vz : vz;
      s2 = ax * ax + az * az;
      s3 = s2 + ay * ay;
      e2 = {33'd0, eps_q} * {33'd0, eps_q};
      p = '0;
      if (s3 > e2) begin
        if (ay < {33'd0, eps_q}) p.y = 0;
        else p.y = vy < 0 ? -h[31:0] : h[31:0];
        if (s2 > e2) begin
          // bitwise integer square root
          s = 0;
          rem = s2;
          for (int b = 31; b >= 0; b--) begin
            t = s | (64'd1 << b);
            if (t * t <= rem) s = t;
          end
          p.x = scale_wall(vx, r, s);
          p.z = scale_wall(vz, r, s);
        end
      end
      expected_points.insert(expected_points.size(), p);
    endfunction

    function void check_point(logic [95:0] got);
      point_t e;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = expected_points.pop_front();
      if (got[31:0] !== e.x) begin
        $display("%0t: point_x expected %h actual %h", $time, e.x, got[31:0]);
        errors++;
      end
      if (got[63:32] !== e.y) begin
        $display("%0t: point_y expected %h actual %h", $time, e.y, got[63:32]);
        errors++;
      end
      if (got[95:64] !== e.z) begin
        $display("%0t: point_z expected %h actual %h", $time, e.z, got[95:64]);
        errors++;
      end
    endfunction
  endclass

  support_scoreboard sb = new();

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_direction(in_tdata);
      if (out_tvalid && out_tready) sb.check_point(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("cylinder_support_point_unit: mismatch");
        $finish;
      end
    end
  end

  // random receiver stalls, with quiet stretches
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [30:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic send_direction(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                logic [30:0] crust, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {1'b0, crust, z, y, x};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 0;
    while (sb.expected_points.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 4) - 2;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return $urandom_range(0, 1) ? $urandom_range(0, 65536 * 4)
                                      : -$urandom_range(0, 65536 * 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_reg();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(0, 3));
      1: return 31'h7fffffff;
      2: return 31'($urandom_range(0, 65536 * 8));
      default: return 31'($urandom);
    endcase
  endfunction

  initial begin
    bit burst;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: reset registers first
    send_direction(0, 0, 0, 0, 1);
    send_direction(1, 0, 0, 0, 1);
    send_direction(0, 32'h10000, 0, 0, 1);
    send_direction(0, -32'sd65536, 0, 0, 1);
    send_direction(32'h10000, 32'h10000, 32'h10000, 0, 1);
    send_direction(32'h80000000, 32'h80000000, 32'h80000000, 0, 1);
    send_direction(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 1);
    send_direction(-32'sd3, 32'h1, 32'd4, 31'd100000, 1);
    send_direction(32'h80000000, 0, 32'h7fffffff, 31'd65536, 1);
    send_direction(3, 5, -1, 0, 0);
    wait_drained();

    write_reg(REG_EPS, 0);
    write_reg(REG_RADIUS, 31'h7fffffff);
    write_reg(REG_HALF_HEIGHT, 31'h7fffffff);
    send_direction(0, 0, 0, 0, 1);
    send_direction(0, 1, 0, 0, 1);
    send_direction(1, 0, 0, 0, 1);
    send_direction(32'h80000000, 32'h80000000, 32'h80000000, 0, 1);
    send_direction(32'h7fffffff, -1, 1, 31'h7fffffff, 1);
    send_direction(-1, 0, -1, 31'd5, 1);
    wait_drained();

    write_reg(REG_EPS, 31'h7fffffff);
    write_reg(REG_RADIUS, 0);
    write_reg(REG_HALF_HEIGHT, 0);
    send_direction(32'h7fffffff, 32'h7fffffff, 0, 31'd7, 1);
    send_direction(32'h80000000, 32'h80000000, 32'h80000000, 31'd7, 1);
    send_direction(32'h10000, 32'h80000000, 0, 0, 1);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_RADIUS, rand_reg());
      write_reg(REG_HALF_HEIGHT, rand_reg());
      write_reg(REG_EPS, ($urandom_range(0, 2) == 0) ? rand_reg()
                                                      : 31'($urandom_range(0, 64)));
      for (int i = 0; i < 50; i++) begin
        burst = (i % 20) < 6;
        send_direction(rand_coord(), rand_coord(), rand_coord(),
                       ($urandom_range(0, 2) == 0) ? rand_reg()
                                                    : 31'($urandom_range(0, 4096)),
                       burst);
      end
      wait_drained();
    end

    if (sb.errors == 0)
      $display("cylinder_support_point_unit: match");
    else
      $display("cylinder_support_point_unit: mismatch");
    $finish;
  end
endmodule
